// ----- rtl/core/fbik_pkg.sv -----
// Shared widths, constants, tables and beat types of the five-bar kinematics pipeline.
package fbik_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_LEN = 24;

  localparam int LEN_W = 15;   // geometry registers
  localparam int POS_W = 16;   // target coordinates
  localparam int ANG_W = 14;   // output angles
  localparam int A_W   = 18;   // 2*x +/- span
  localparam int B_W   = 17;   // 2*y
  localparam int HSQ_W = 36;   // a*a + b*b
  localparam int K_W   = 34;   // 4*L1^2 - 4*L2^2
  localparam int NUM_W = 38;   // law-of-cosines numerator
  localparam int H_W   = 26;   // sqrt(hsq * 2^16)
  localparam int DEN_W = 43;   // 4*L1*h
  localparam int MAG_W = 46;   // |num| * 256
  localparam int REM_W = 44;   // divider remainder
  localparam int C_W   = 21;   // Q20 cosine and sine
  localparam int V_W   = 34;   // CORDIC vector
  localparam int Z_W   = 32;   // angle, 2^-22 degree
  localparam int ACC_W = 33;   // combined motor angle

  localparam logic signed [Z_W-1:0] HALF_TURN = 32'sd754974720;

  localparam int FIRST_MIN  = 1600;
  localparam int FIRST_MAX  = 11520;
  localparam int SECOND_MIN = 0;
  localparam int SECOND_MAX = 9920;

  localparam int REG_BASE_SPAN = 0;
  localparam int REG_UPPER_ARM = 1;
  localparam int REG_FOREARM   = 2;

  localparam logic [LEN_W-1:0] BASE_SPAN_RST = 15'd1280;
  localparam logic [LEN_W-1:0] UPPER_ARM_RST = 15'd1600;
  localparam logic [LEN_W-1:0] FOREARM_RST   = 15'd2400;

  // atan(2^-i) in 2^-22 degree
  localparam logic [27:0] ATAN_DEG [ATAN_LEN] = '{
    28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485, 28'd15000234, 28'd7507429,
    28'd3754631,   28'd1877430,   28'd938729,   28'd469366,   28'd234683,   28'd117342,
    28'd58671,     28'd29335,     28'd14668,    28'd7334,     28'd3667,     28'd1833,
    28'd917,       28'd458,       28'd229,      28'd115,      28'd57,       28'd29
  };

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic [HSQ_W-1:0]      hsq;
    logic                  flag;
  } lane_in_t;

  typedef struct packed {
    logic signed [Z_W-1:0] elbow;
    logic signed [Z_W-1:0] theta;
    logic                  a_neg;
    logic                  a_zero;
    logic                  flag;
  } lane_out_t;

endpackage

// ----- rtl/core/fbik_front.sv -----
// Front end: axis offsets, squared distances and the law-of-cosines constant.
module fbik_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [fbik_pkg::POS_W-1:0] target_x,
  input  logic signed [fbik_pkg::POS_W-1:0] target_y,
  input  logic [fbik_pkg::LEN_W-1:0]    base_span,
  input  logic [fbik_pkg::LEN_W-1:0]    upper_arm_length,
  input  logic [fbik_pkg::LEN_W-1:0]    forearm_length,
  output logic                          out_valid,
  output fbik_pkg::lane_in_t            left_o,
  output fbik_pkg::lane_in_t            right_o,
  output logic signed [fbik_pkg::K_W-1:0] k_o
);
  import fbik_pkg::*;

  logic                  v1_r, v2_r;
  logic signed [A_W-1:0] al_r, ar_r, al_nxt, ar_nxt;
  logic signed [B_W-1:0] b_r, b_nxt;
  logic                  origin_r, origin_nxt;
  logic signed [HSQ_W-1:0] sqal, sqar, sqb;
  lane_in_t              left_r, right_r, left_nxt, right_nxt;
  logic [2*LEN_W-1:0]    la2, lb2;
  logic signed [K_W-1:0] k_r, k_nxt;

  always_comb begin
    al_nxt     = {target_x[POS_W-1], target_x, 1'b0} + {3'b000, base_span};
    ar_nxt     = {target_x[POS_W-1], target_x, 1'b0} - {3'b000, base_span};
    b_nxt      = {target_y, 1'b0};
    origin_nxt = (target_x == '0) && (target_y == '0);
  end

  always_comb begin
    sqal = al_r * al_r;
    sqar = ar_r * ar_r;
    sqb  = b_r * b_r;
    left_nxt.a     = al_r;
    left_nxt.b     = b_r;
    left_nxt.hsq   = $unsigned(sqal) + $unsigned(sqb);
    left_nxt.flag  = origin_r;
    right_nxt.a    = ar_r;
    right_nxt.b    = b_r;
    right_nxt.hsq  = $unsigned(sqar) + $unsigned(sqb);
    right_nxt.flag = 1'b0;
  end

  // geometry constant follows the registers; the user must change them only while idle, no logic here enforces it
  always_comb begin
    la2   = upper_arm_length * upper_arm_length;
    lb2   = forearm_length * forearm_length;
    k_nxt = $signed({2'b00, la2, 2'b00}) - $signed({2'b00, lb2, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (en) begin
      al_r     <= al_nxt;
      ar_r     <= ar_nxt;
      b_r      <= b_nxt;
      origin_r <= origin_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
    end
  end

  assign out_valid = v2_r;
  assign left_o    = left_r;
  assign right_o   = right_r;
  assign k_o       = k_r;

endmodule

// ----- rtl/core/fbik_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with side payload.
module fbik_isqrt #(
  parameter int RW    = 26,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2*RW-1:0]  in_value,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_valid,
  output logic [RW-1:0]    out_root,
  output logic [PAY_W-1:0] out_pay
);
  localparam int VW = 2 * RW;

  typedef struct packed {
    logic [VW-1:0]    rem;
    logic [RW-1:0]    root;
    logic [PAY_W-1:0] pay;
  } sq_stage_t;

  sq_stage_t   stg_r [RW];
  logic [RW-1:0] vld_r;

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int K = RW - 1 - j;
    sq_stage_t     src;
    sq_stage_t     stg_nxt;
    logic [VW-1:0] trial;

    if (j == 0) begin : g_first
      assign src = '{rem: in_value, root: '0, pay: in_pay};
    end else begin : g_next
      assign src = stg_r[j-1];
    end

    // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
    always_comb begin
      trial   = ({{RW{1'b0}}, src.root} << (K + 1)) + (VW'(1) << (2 * K));
      stg_nxt = src;
      if (src.rem >= trial) begin
        stg_nxt.rem  = src.rem - trial;
        stg_nxt.root = src.root | (RW'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (en) stg_r[j] <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RW-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = stg_r[RW-1].root;
  assign out_pay   = stg_r[RW-1].pay;

endmodule

// ----- rtl/core/fbik_cordic.sv -----
// Pipelined vectoring CORDIC: angle of (vx, vy) for vx >= 0, one rotation per stage.
module fbik_cordic #(
  parameter int N = fbik_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [fbik_pkg::V_W-1:0] in_vx,
  input  logic signed [fbik_pkg::V_W-1:0] in_vy,
  output logic                            out_valid,
  output logic signed [fbik_pkg::Z_W-1:0] out_z
);
  import fbik_pkg::*;

  typedef struct packed {
    logic signed [V_W-1:0] vx;
    logic signed [V_W-1:0] vy;
    logic signed [Z_W-1:0] z;
  } cr_stage_t;

  cr_stage_t   stg_r [N];
  logic [N-1:0] vld_r;

  for (genvar i = 0; i < N; i++) begin : g_rot
    cr_stage_t             src;
    cr_stage_t             stg_nxt;
    logic signed [V_W-1:0] vx, vy, dx, dy;
    logic signed [Z_W-1:0] step;

    if (i == 0) begin : g_first
      assign src = '{vx: in_vx, vy: in_vy, z: '0};
    end else begin : g_next
      assign src = stg_r[i-1];
    end

    always_comb begin
      vx   = src.vx;
      vy   = src.vy;
      dx   = vy >>> i;
      dy   = vx >>> i;
      step = $signed({{(Z_W-28){1'b0}}, ATAN_DEG[i]});
      if (vy > 0) begin
        stg_nxt.vx = vx + dx;
        stg_nxt.vy = vy - dy;
        stg_nxt.z  = src.z + step;
      end else begin
        stg_nxt.vx = vx - dx;
        stg_nxt.vy = vy + dy;
        stg_nxt.z  = src.z - step;
      end
    end

    always_ff @(posedge clk) begin
      if (en) stg_r[i] <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_z     = stg_r[N-1].z;

endmodule

// ----- rtl/core/fbik_lane.sv -----
// One motor axis: distance root, cosine division, sine root and the two angle CORDICs.
module fbik_lane #(
  parameter int CORDIC_ITERATIONS = fbik_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  fbik_pkg::lane_in_t              in_d,
  input  logic [fbik_pkg::LEN_W-1:0]      upper_arm_length,
  input  logic signed [fbik_pkg::K_W-1:0] k,
  output logic                            out_valid,
  output fbik_pkg::lane_out_t             out_d
);
  import fbik_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic                  flag;
  } geo_t;

  typedef struct packed {
    logic [HSQ_W-1:0] hsq;
    geo_t             geo;
  } hpay_t;

  typedef struct packed {
    logic num_neg;
    logic sat;
    geo_t geo;
  } dpay_t;

  typedef struct packed {
    logic [C_W-1:0] c;
    dpay_t          dp;
  } spay_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [C_W-1:0]   q;
    dpay_t            pay;
  } div_stage_t;

  typedef struct packed {
    logic num_neg;
    logic sat;
    logic a_neg;
    logic a_zero;
    logic ab_zero;
    logic flag;
  } tail_t;

  // distance root
  hpay_t          hp_in, hp_out;
  logic           h_valid;
  logic [H_W-1:0] h_root;

  assign hp_in = '{hsq: in_d.hsq, geo: '{a: in_d.a, b: in_d.b, flag: in_d.flag}};

  fbik_isqrt #(.RW(H_W), .PAY_W($bits(hpay_t))) u_sqrt_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_value ({in_d.hsq, 16'h0000}),
    .in_pay   (hp_in),
    .out_valid(h_valid),
    .out_root (h_root),
    .out_pay  (hp_out)
  );

  // denominator and numerator
  logic                    d1_v_r;
  logic [DEN_W-1:0]        den_r;
  logic signed [NUM_W-1:0] num_r;
  geo_t                    geo1_r;
  logic [DEN_W-3:0]        lah;

  assign lah = upper_arm_length * h_root;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= {lah, 2'b00};
      num_r  <= {{(NUM_W-K_W){k[K_W-1]}}, k} + $signed({2'b00, hp_out.hsq});
      geo1_r <= hp_out.geo;
    end
  end

  // range check ahead of the divider
  logic                    d2_v_r;
  div_stage_t              d2_r;
  logic [NUM_W-1:0]        absnum;
  logic [MAG_W-1:0]        mag;
  div_stage_t              d2_nxt;

  always_comb begin
    absnum          = num_r[NUM_W-1] ? $unsigned(-num_r) : $unsigned(num_r);
    mag             = {absnum, 8'h00};
    d2_nxt.rem      = {1'b0, mag[DEN_W-1:0]};
    d2_nxt.den      = den_r;
    d2_nxt.q        = '0;
    d2_nxt.pay.num_neg = num_r[NUM_W-1];
    d2_nxt.pay.sat  = (den_r == '0) || (mag > {{(MAG_W-DEN_W){1'b0}}, den_r});
    d2_nxt.pay.geo  = geo1_r;
  end

  always_ff @(posedge clk) begin
    if (en) d2_r <= d2_nxt;
  end

  // restoring divider, one quotient bit per stage: c = |num|*2^28 / den
  div_stage_t     div_r [C_W];
  logic [C_W-1:0] div_v_r;

  for (genvar i = 0; i < C_W; i++) begin : g_div
    div_stage_t       src;
    div_stage_t       stg_nxt;
    logic [REM_W-1:0] x;
    logic             qb;

    if (i == 0) begin : g_first
      assign src = d2_r;
      assign x   = src.rem;
    end else begin : g_next
      assign src = div_r[i-1];
      assign x   = {src.rem[REM_W-2:0], 1'b0};
    end

    always_comb begin
      qb          = x >= {1'b0, src.den};
      stg_nxt     = src;
      stg_nxt.rem = qb ? x - {1'b0, src.den} : x;
      stg_nxt.q   = {src.q[C_W-2:0], qb};
    end

    always_ff @(posedge clk) begin
      if (en) div_r[i] <= stg_nxt;
    end
  end

  // sine argument
  logic             c1_v_r;
  logic [2*C_W-1:0] sval_r;
  spay_t            sp_r;
  logic [2*C_W-1:0] csq;

  assign csq = div_r[C_W-1].q * div_r[C_W-1].q;

  always_ff @(posedge clk) begin
    if (en) begin
      sval_r <= ((2*C_W)'(1) << 40) - csq;
      sp_r   <= '{c: div_r[C_W-1].q, dp: div_r[C_W-1].pay};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r  <= 1'b0;
      d2_v_r  <= 1'b0;
      div_v_r <= '0;
      c1_v_r  <= 1'b0;
    end else if (en) begin
      d1_v_r  <= h_valid;
      d2_v_r  <= d1_v_r;
      div_v_r <= {div_v_r[C_W-2:0], d2_v_r};
      c1_v_r  <= div_v_r[C_W-1];
    end
  end

  // sine root
  spay_t          sp_out;
  logic           s_valid;
  logic [C_W-1:0] s_root;

  fbik_isqrt #(.RW(C_W), .PAY_W($bits(spay_t))) u_sqrt_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (c1_v_r),
    .in_value (sval_r),
    .in_pay   (sp_r),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_pay  (sp_out)
  );

  // elbow and direction angles side by side
  logic signed [V_W-1:0] ex, ey, dx, dy;
  logic [A_W-1:0]        amag;
  geo_t                  g;
  tail_t                 tail_in;
  tail_t                 tail_r [N];
  logic                  ez_valid, dz_valid;
  logic signed [Z_W-1:0] ez, dz;

  always_comb begin
    g       = sp_out.dp.geo;
    amag    = g.a[A_W-1] ? $unsigned(-g.a) : $unsigned(g.a);
    ex      = $signed({{(V_W-C_W-8){1'b0}}, sp_out.c, 8'h00});
    ey      = $signed({{(V_W-C_W-8){1'b0}}, s_root, 8'h00});
    dx      = $signed({{(V_W-A_W-11){1'b0}}, amag[A_W-2:0], 12'h000});
    dy      = $signed({{(V_W-B_W-12){g.b[B_W-1]}}, g.b, 12'h000});
    tail_in.num_neg = sp_out.dp.num_neg;
    tail_in.sat     = sp_out.dp.sat;
    tail_in.a_neg   = g.a[A_W-1];
    tail_in.a_zero  = (g.a == '0);
    tail_in.ab_zero = (g.a == '0) && (g.b == '0);
    tail_in.flag    = g.flag;
  end

  fbik_cordic #(.N(N)) u_cordic_elbow (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s_valid),
    .in_vx    (ex),
    .in_vy    (ey),
    .out_valid(ez_valid),
    .out_z    (ez)
  );

  fbik_cordic #(.N(N)) u_cordic_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s_valid),
    .in_vx    (dx),
    .in_vy    (dy),
    .out_valid(dz_valid),
    .out_z    (dz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0] <= tail_in;
      for (int i = 1; i < N; i++) tail_r[i] <= tail_r[i-1];
    end
  end

  // fold in the special cases
  logic      out_v_r;
  lane_out_t out_r, out_nxt;
  tail_t     t;

  always_comb begin
    t = tail_r[N-1];
    if (t.sat) out_nxt.elbow = t.num_neg ? HALF_TURN : '0;
    else       out_nxt.elbow = t.num_neg ? HALF_TURN - ez : ez;
    out_nxt.theta  = t.ab_zero ? '0 : dz;
    out_nxt.a_neg  = t.a_neg;
    out_nxt.a_zero = t.a_zero;
    out_nxt.flag   = t.flag | t.sat | t.ab_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= ez_valid & dz_valid;
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_d     = out_r;

endmodule

// ----- rtl/core/fbik_back.sv -----
// Back end: combine both axes into motor angles, round to 1/64 degree and clamp.
module fbik_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        left_valid,
  input  logic                        right_valid,
  input  fbik_pkg::lane_out_t         left_d,
  input  fbik_pkg::lane_out_t         right_d,
  output logic                        out_valid,
  output logic [fbik_pkg::ANG_W-1:0]  first_motor_angle,
  output logic [fbik_pkg::ANG_W-1:0]  second_motor_angle,
  output logic                        out_of_reach
);
  import fbik_pkg::*;

  localparam int RND_W = ACC_W + 1;

  function automatic logic [ANG_W-1:0] to_output(logic signed [ACC_W-1:0] v, int lo, int hi);
    logic signed [RND_W-1:0] r;
    logic [ANG_W-1:0]        res;
    r = (RND_W'(v) + RND_W'(32768)) >>> 16;
    if (r > RND_W'(hi))      res = ANG_W'(hi);
    else if (r < RND_W'(lo)) res = ANG_W'(lo);
    else                     res = r[ANG_W-1:0];
    return res;
  endfunction

  logic                    v1_r, v2_r;
  logic signed [ACC_W-1:0] first_r, second_r;
  logic                    flag1_r;
  logic signed [Z_W-1:0]   dl, dr;
  logic [ANG_W-1:0]        fa_r, sa_r;
  logic                    flag2_r;

  always_comb begin
    dl = (left_d.a_neg || left_d.a_zero) ? HALF_TURN - left_d.theta : left_d.theta;
    dr = right_d.a_neg ? right_d.theta : HALF_TURN - right_d.theta;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_r  <= ACC_W'(left_d.elbow) + ACC_W'(dl);
      second_r <= ACC_W'(HALF_TURN) - ACC_W'(dr) - ACC_W'(right_d.elbow);
      flag1_r  <= left_d.flag | right_d.flag;
      fa_r     <= to_output(first_r, FIRST_MIN, FIRST_MAX);
      sa_r     <= to_output(second_r, SECOND_MIN, SECOND_MAX);
      flag2_r  <= flag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= left_valid & right_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid          = v2_r;
  assign first_motor_angle  = fa_r;
  assign second_motor_angle = sa_r;
  assign out_of_reach       = flag2_r;

endmodule

// ----- rtl/core/five_bar_inverse_kinematics.sv -----
// Top level of the five-bar arm inverse kinematics pipeline.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in_     | slave     | tvalid/tready          | target point (x, y), 1/16 mm
//  out_    | master    | tvalid/tready          | two motor angles (1/64 deg) + flag
//  cfg_    | APB slave | psel/penable, pready=1 | base_span, upper_arm, forearm
//
// One beat is accepted per cycle unless the pipeline is stalled; the path runs through the
// two pipelined square roots (26 and 21 stages), the 21-stage divider and the CORDIC.
// Synchronous active-low reset clears valid and skid flags and presets the config registers.
// Stall: the whole pipeline holds on a single enable; an output register plus one
// skid entry take the last beat, so a held result does not block the next input.
module five_bar_inverse_kinematics #(
  parameter int CORDIC_ITERATIONS = fbik_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] target_x, [31:16] target_y
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [13:0] first_motor_angle, [27:14] second_motor_angle, pad
  output logic        out_tuser,  // [0] out_of_reach
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fbik_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [LEN_W-1:0] base_span_r, upper_arm_r, forearm_r;
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_span_r <= BASE_SPAN_RST;
      upper_arm_r <= UPPER_ARM_RST;
      forearm_r   <= FOREARM_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        2'(REG_BASE_SPAN): base_span_r <= cfg_pwdata[LEN_W-1:0];
        2'(REG_UPPER_ARM): upper_arm_r <= cfg_pwdata[LEN_W-1:0];
        2'(REG_FOREARM):   forearm_r   <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      2'(REG_BASE_SPAN): cfg_prdata = {17'h0, base_span_r};
      2'(REG_UPPER_ARM): cfg_prdata = {17'h0, upper_arm_r};
      2'(REG_FOREARM):   cfg_prdata = {17'h0, forearm_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  logic                  pipe_en;
  logic                  front_valid;
  lane_in_t              left_in, right_in;
  logic signed [K_W-1:0] k;
  logic                  left_valid, right_valid;
  lane_out_t             left_out, right_out;
  logic                  back_valid;
  logic [ANG_W-1:0]      first_a, second_a;
  logic                  reach_flag;

  fbik_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (pipe_en),
    .in_valid        (in_tvalid),
    .target_x        (in_tdata[15:0]),
    .target_y        (in_tdata[31:16]),
    .base_span       (base_span_r),
    .upper_arm_length(upper_arm_r),
    .forearm_length  (forearm_r),
    .out_valid       (front_valid),
    .left_o          (left_in),
    .right_o         (right_in),
    .k_o             (k)
  );

  // left motor axis at -span/2, right at +span/2
  fbik_lane #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lane_left (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (pipe_en),
    .in_valid        (front_valid),
    .in_d            (left_in),
    .upper_arm_length(upper_arm_r),
    .k               (k),
    .out_valid       (left_valid),
    .out_d           (left_out)
  );

  fbik_lane #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_lane_right (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (pipe_en),
    .in_valid        (front_valid),
    .in_d            (right_in),
    .upper_arm_length(upper_arm_r),
    .k               (k),
    .out_valid       (right_valid),
    .out_d           (right_out)
  );

  fbik_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (pipe_en),
    .left_valid        (left_valid),
    .right_valid       (right_valid),
    .left_d            (left_out),
    .right_d           (right_out),
    .out_valid         (back_valid),
    .first_motor_angle (first_a),
    .second_motor_angle(second_a),
    .out_of_reach      (reach_flag)
  );

  // ---------------------------------------------------------------- output + skid
  logic [ANG_W-1:0] out_first_r, out_second_r, spare_first_r, spare_second_r;
  logic             out_flag_r, spare_flag_r;
  logic             out_v_r, spare_v_r;
  logic             take;

  // pipeline only blocks when a beat is due and the skid entry is occupied
  assign pipe_en   = !back_valid || !spare_v_r;
  assign in_tready = pipe_en;
  assign take      = pipe_en && back_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (spare_v_r) begin
        out_v_r   <= 1'b1;
        spare_v_r <= 1'b0;
      end else begin
        out_v_r   <= take;
      end
    end else if (take) begin
      spare_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (spare_v_r) begin
        out_first_r  <= spare_first_r;
        out_second_r <= spare_second_r;
        out_flag_r   <= spare_flag_r;
      end else begin
        out_first_r  <= first_a;
        out_second_r <= second_a;
        out_flag_r   <= reach_flag;
      end
    end else if (take) begin
      spare_first_r  <= first_a;
      spare_second_r <= second_a;
      spare_flag_r   <= reach_flag;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'h0, out_second_r, out_first_r};
  assign out_tuser  = out_flag_r;

endmodule
